// ===== hw/rtl/gbw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package gbw_pkg;
	localparam int MAX_WIDTH = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int COL_W = 10;
	localparam int ROW_W = 12;
	localparam int NUM_LINES = 4;
	localparam int NUM_W = 6;
	localparam int QUEUE_DEPTH = 8;

	// register indexes
	localparam logic [2:0] REG_WIDTH  = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd1;
	localparam logic [2:0] REG_W0     = 3'd2;
	localparam logic [2:0] REG_W1     = 3'd3;
	localparam logic [2:0] REG_W2     = 3'd4;
	localparam logic [2:0] REG_W4     = 3'd5;
	localparam logic [2:0] REG_W5     = 3'd6;
	localparam logic [2:0] REG_W8     = 3'd7;

	typedef logic [15:0] weight_t;
	typedef weight_t [NUM_W-1:0] weights_t;

	// one classified window column handed from front to back
	typedef struct packed {
		logic [4:0][7:0] column;
		logic            emit;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} col_item_t;

	// weight class by squared distance, row k, column j
	function automatic logic [2:0] tap_class(input int k, input int j);
		int dk;
		int dj;
		int d;
		dk = (k > 2) ? k - 2 : 2 - k;
		dj = (j > 2) ? j - 2 : 2 - j;
		d = dk * dk + dj * dj;
		case (d)
			0: tap_class = 3'd0;
			1: tap_class = 3'd1;
			2: tap_class = 3'd2;
			4: tap_class = 3'd3;
			5: tap_class = 3'd4;
			default: tap_class = 3'd5;
		endcase
	endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/gaussian_blur_window_filter.sv =====
// 5x5 gaussian blur on a raster pixel stream. one pixel beat is taken every clock
// while the output queue has room; four line stores (one 1024x32 ram, read and
// written once per pixel) feed a sliding 5x5 window. a front part tracks row and
// column and reads the line ram, a back part multiplies the 25 taps by weights
// chosen by squared distance, sums, rounds and saturates. a result is offered
// after the front and back pipeline registers and the output queue. border pixels
// give no result. a small output queue absorbs results while the sink stalls; input
// ready drops when the results in flight could overfill it.
`timescale 1ns / 1ps
`default_nettype none
module gaussian_blur_window_filter import gbw_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic valid,
	output logic ready,
	input  wire logic [7:0] pixel_value,
	input  wire logic frame_start,
	output logic out_valid,
	input  wire logic out_ready,
	output logic [7:0] filtered_value,
	output logic [11:0] center_row,
	output logic [9:0] center_col,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [4:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic [10:0] width_q;
	logic [12:0] height_q;
	weights_t weights_q;
	logic [2:0] ridx;
	logic in_fire;
	col_item_t item_s2;
	logic v_s2;
	logic b_valid;
	logic [7:0] b_val;
	logic [11:0] b_row;
	logic [9:0] b_col;
	logic [29:0] q_mem [QUEUE_DEPTH];
	logic [2:0] wp_q, rp_q;
	logic [3:0] cnt_q;
	logic [3:0] inflight_q;
	logic pop;

	assign pready = 1'b1;
	assign ridx = paddr[4:2];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 11'd1024;
			height_q <= 13'd1024;
			weights_q <= {16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd65535};
		end else if (psel && penable && pwrite) begin
			case (ridx)
				REG_WIDTH:  width_q <= pwdata[10:0];
				REG_HEIGHT: height_q <= pwdata[12:0];
				default:    weights_q[ridx - REG_W0] <= pwdata[15:0];
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_WIDTH:  prdata = 32'(width_q);
			REG_HEIGHT: prdata = 32'(height_q);
			default:    prdata = 32'(weights_q[ridx - REG_W0]);
		endcase
	end

	// every pixel in flight may become a result; reserve queue room for it
	assign ready = (5'(cnt_q) + 5'(inflight_q)) < 5'(QUEUE_DEPTH);
	assign in_fire = valid && ready;
	assign pop = out_valid && out_ready;

	gbw_front u_front (
		.clk, .arst_n, .in_fire, .pixel_value, .frame_start,
		.line_width(width_q), .frame_height(height_q),
		.item_s2, .valid_s2(v_s2)
	);

	gbw_back u_back (
		.clk, .arst_n, .in_valid(v_s2), .in_item(item_s2), .weights(weights_q),
		.out_valid(b_valid), .filtered_value(b_val), .center_row(b_row),
		.center_col(b_col)
	);

	// pixels accepted whose outcome has not yet reached the queue (6 stages)
	logic [5:0] pipe_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_q <= '0;
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			pipe_q <= {pipe_q[4:0], in_fire};
			if (b_valid) wp_q <= wp_q + 3'd1;
			if (pop) rp_q <= rp_q + 3'd1;
			cnt_q <= cnt_q + 4'(b_valid) - 4'(pop);
		end
	end
	assign inflight_q = 4'($countones(pipe_q));

	always_ff @(posedge clk) begin
		if (b_valid) q_mem[wp_q] <= {b_val, b_row, b_col};
	end

	assign out_valid = cnt_q != 4'd0;
	assign {filtered_value, center_row, center_col} = q_mem[rp_q];

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 4'(QUEUE_DEPTH))
		else $error("result queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		!(b_valid && cnt_q == 4'(QUEUE_DEPTH)))
		else $error("push into full queue");
	assert property (@(posedge clk) disable iff (!arst_n) (cnt_q == 4'd0) |-> !pop)
		else $error("pop from empty queue");
endmodule
`default_nettype wire

// ===== hw/rtl/gbw_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gbw_front import gbw_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_fire,
	input  wire logic [7:0] pixel_value,
	input  wire logic frame_start,
	input  wire logic [10:0] line_width,
	input  wire logic [12:0] frame_height,
	output col_item_t item_s2,
	output logic valid_s2
);
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_c;
	logic [ROW_W-1:0] row_c;
	logic [11:0] width_c;
	logic [12:0] height_c;
	logic [10:0] col_nx;
	logic [12:0] row_nx;
	logic [NUM_LINES*8-1:0] mem [MAX_WIDTH];
	logic [NUM_LINES*8-1:0] rd_s2;
	logic [7:0] px_s1;
	logic v_s1;
	logic emit_s1;
	logic [ROW_W-1:0] row_s1;
	logic [COL_W-1:0] col_s1;
	logic [COL_W-1:0] wa_s1;
	logic [NUM_LINES*8-1:0] rd_q;
	logic byp_s1;
	logic [NUM_LINES*8-1:0] byp_d_s1;
	logic [7:0] px_s2;
	logic emit_s2;
	logic [ROW_W-1:0] row_s2;
	logic [COL_W-1:0] col_s2;

	always_comb begin
		width_c = (line_width > 11'(MAX_WIDTH)) ? 12'(MAX_WIDTH) : 12'(line_width);
		height_c = (frame_height > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : frame_height;
		col_c = frame_start ? '0 : col_q;
		row_c = frame_start ? '0 : row_q;
		col_nx = 11'(col_c) + 11'd1;
		row_nx = 13'(row_c);
		if (12'(col_nx) >= width_c) begin
			col_nx = '0;
			row_nx = 13'(row_c) + 13'd1;
			if (row_nx >= height_c) row_nx = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			v_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			v_s1 <= in_fire;
			valid_s2 <= v_s1;
			if (in_fire) begin
				col_q <= col_nx[COL_W-1:0];
				row_q <= row_nx[ROW_W-1:0];
			end
		end
	end

	// read in stage 1, write back shifted column in stage 2
	always_ff @(posedge clk) begin
		if (in_fire) begin
			px_s1 <= pixel_value;
			row_s1 <= row_c;
			col_s1 <= col_c;
			emit_s1 <= (row_c >= 12'd4) && (col_c >= 10'd4);
			rd_q <= mem[col_c];
			// the column being written back this edge is not yet in the ram
			byp_s1 <= valid_s2 && (wa_s1 == col_c);
			byp_d_s1 <= {rd_s2[23:0], px_s2};
		end
		px_s2 <= px_s1;
		row_s2 <= row_s1;
		col_s2 <= col_s1;
		emit_s2 <= emit_s1;
		wa_s1 <= col_s1;
		// forward a write to the same column that is in flight
		if (v_s1 && valid_s2 && wa_s1 == col_s1)
			rd_s2 <= {rd_s2[23:0], px_s2};
		else if (byp_s1)
			rd_s2 <= byp_d_s1;
		else
			rd_s2 <= rd_q;
		if (valid_s2)
			mem[wa_s1] <= {rd_s2[23:0], px_s2};
	end

	always_comb begin
		item_s2.column[0] = rd_s2[31:24];
		item_s2.column[1] = rd_s2[23:16];
		item_s2.column[2] = rd_s2[15:8];
		item_s2.column[3] = rd_s2[7:0];
		item_s2.column[4] = px_s2;
		item_s2.emit = emit_s2;
		item_s2.row = row_s2 - 12'd2;
		item_s2.col = col_s2 - 10'd2;
	end
endmodule
`default_nettype wire

// ===== hw/rtl/gbw_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gbw_back import gbw_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  col_item_t in_item,
	input  weights_t weights,
	output logic out_valid,
	output logic [7:0] filtered_value,
	output logic [ROW_W-1:0] center_row,
	output logic [COL_W-1:0] center_col
);
	logic [4:0][4:0][7:0] win_q;
	logic [4:0][4:0][7:0] win_c;
	logic [4:0][4:0][23:0] p_c;
	logic v_s1, v_s2;
	logic [ROW_W-1:0] row_s1, row_s2;
	logic [COL_W-1:0] col_s1, col_s2;
	logic [4:0][26:0] rs_c;
	logic [4:0][26:0] rs_q;
	logic [4:0][26:0] rs_s2;
	logic [28:0] acc_c;
	logic [28:0] rnd_c;

	always_comb begin
		for (int k = 0; k < 5; k++) begin
			for (int j = 0; j < 4; j++) win_c[k][j] = win_q[k][j+1];
			win_c[k][4] = in_item.column[k];
		end
		for (int k = 0; k < 5; k++)
			for (int j = 0; j < 5; j++)
				p_c[k][j] = 24'(win_c[k][j]) * 24'(weights[tap_class(k, j)]);
		for (int k = 0; k < 5; k++)
			rs_c[k] = 27'(p_c[k][0]) + 27'(p_c[k][1]) + 27'(p_c[k][2])
				+ 27'(p_c[k][3]) + 27'(p_c[k][4]);
		acc_c = '0;
		for (int k = 0; k < 5; k++) acc_c = acc_c + 29'(rs_s2[k]);
		rnd_c = acc_c + 29'd32768;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1 <= in_valid && in_item.emit;
			v_s2 <= v_s1;
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) win_q <= win_c;
		row_s1 <= in_item.row;
		col_s1 <= in_item.col;
		row_s2 <= row_s1;
		col_s2 <= col_s1;
		center_row <= row_s2;
		center_col <= col_s2;
		rs_s2 <= rs_q;
		filtered_value <= (rnd_c[28:16] > 13'd255) ? 8'd255 : rnd_c[23:16];
	end

	always_ff @(posedge clk) rs_q <= rs_c;

	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> $past(v_s1, 2))
		else $error("result without window");
	assert property (@(posedge clk) disable iff (!arst_n) v_s1 |=> v_s2)
		else $error("pipe lost item");
	assert property (@(posedge clk) disable iff (!arst_n) v_s2 |=> out_valid)
		else $error("result dropped");
endmodule
`default_nettype wire

// ===== tb/sv/gaussian_blur_window_filter_tb.sv =====
`timescale 1ns / 1ps
module gaussian_blur_window_filter_tb;
	import gbw_pkg::*;

	// one expected filtered pixel
	typedef struct {
		logic [7:0]  value;
		logic [11:0] row;
		logic [9:0]  col;
	} blur_result_t;

	// tracks the filter: its own line stores, window, counters and registers
	class blur_scoreboard;
		logic [7:0]   lines [NUM_LINES][MAX_WIDTH];
		logic [7:0]   win [5][5];
		int unsigned  col_pos, row_pos;
		int unsigned  width_reg, height_reg;
		int unsigned  weight [NUM_W];
		blur_result_t pending [$];
		int           failures;
		int           mismatches;

		function new();
			width_reg = 1024;
			height_reg = 1024;
			weight[0] = 65535;
			for (int i = 1; i < NUM_W; i++) weight[i] = 0;
			col_pos = 0;
			row_pos = 0;
			failures = 0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [2:0] idx, int unsigned val);
			case (idx)
				REG_WIDTH:  width_reg = val & 32'h7ff;
				REG_HEIGHT: height_reg = val & 32'h1fff;
				default:    weight[idx - REG_W0] = val & 32'hffff;
			endcase
		endfunction

		// weight class from squared distance of tap (k, j) to the centre
		function int unsigned class_of(int k, int j);
			int d;
			d = (k - 2) * (k - 2) + (j - 2) * (j - 2);
			case (d)
				0: return 0;
				1: return 1;
				2: return 2;
				4: return 3;
				5: return 4;
				default: return 5;
			endcase
		endfunction

		// a pixel beat went in: shift stores and window, maybe expect a result
		function void note_pixel(logic [7:0] px, logic fs);
			int unsigned eff_w, eff_h, c, r;
			logic [7:0] column [5];
			longint unsigned acc;
			blur_result_t res;
			eff_w = (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
			eff_h = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
			if (fs) begin
				col_pos = 0;
				row_pos = 0;
			end
			c = col_pos % MAX_WIDTH;
			r = row_pos;
			column[0] = lines[3][c];
			column[1] = lines[2][c];
			column[2] = lines[1][c];
			column[3] = lines[0][c];
			column[4] = px;
			lines[3][c] = lines[2][c];
			lines[2][c] = lines[1][c];
			lines[1][c] = lines[0][c];
			lines[0][c] = px;
			for (int k = 0; k < 5; k++) begin
				for (int j = 0; j < 4; j++) win[k][j] = win[k][j + 1];
				win[k][4] = column[k];
			end
			if (r >= 4 && c >= 4) begin
				acc = 0;
				for (int k = 0; k < 5; k++)
					for (int j = 0; j < 5; j++)
						acc += longint'(win[k][j]) * weight[class_of(k, j)];
				acc = (acc + 32768) >> 16;
				res.value = (acc > 255) ? 8'd255 : acc[7:0];
				res.row = 12'(r - 2);
				res.col = 10'(c - 2);
				pending.push_back(res);
			end
			c++;
			if (c >= eff_w) begin
				c = 0;
				r++;
				if (r >= eff_h) r = 0;
			end
			col_pos = c;
			row_pos = r;
		endfunction

		function void check_result(logic [7:0] v, logic [11:0] r, logic [9:0] c);
			blur_result_t e;
			if (pending.size() == 0) begin
				failures++;
				if (mismatches++ < 10)
					$display("unexpected result value %0d row %0d col %0d", v, r, c);
				return;
			end
			e = pending.pop_front();
			if (v !== e.value || r !== e.row || c !== e.col) begin
				failures++;
				if (mismatches++ < 10)
					$display("mismatch: expected %0d @(%0d,%0d) got %0d @(%0d,%0d)",
						e.value, e.row, e.col, v, r, c);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic valid, ready;
	logic [7:0] pixel_value;
	logic frame_start;
	logic out_valid, out_ready;
	logic [7:0] filtered_value;
	logic [11:0] center_row;
	logic [9:0] center_col;
	logic psel, penable, pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;

	blur_scoreboard blur_sb;
	bit calm;          // no idling on either side in the closing stretch
	int sink_stall;    // cycles left in the current sink stall burst
	int sink_run;      // cycles left before the sink may stall again

	gaussian_blur_window_filter DUT (
		.clk(clk), .arst_n(arst_n),
		.valid(valid), .ready(ready),
		.pixel_value(pixel_value), .frame_start(frame_start),
		.out_valid(out_valid), .out_ready(out_ready),
		.filtered_value(filtered_value), .center_row(center_row),
		.center_col(center_col),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// run ceiling, well above the slowest correct run
	initial begin
		#4000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// sink side: check each result beat, stall in random bursts
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			blur_sb.check_result(filtered_value, center_row, center_col);
		if (calm) begin
			out_ready <= 1'b1;
		end else if (sink_stall > 0) begin
			sink_stall <= sink_stall - 1;
			out_ready <= (sink_stall == 1);
		end else if (sink_run > 0) begin
			sink_run <= sink_run - 1;
			out_ready <= 1'b1;
		end else if ($urandom_range(0, 2) == 0) begin
			sink_stall <= $urandom_range(1, 16);
			out_ready <= 1'b0;
		end else begin
			sink_run <= $urandom_range(0, 30);
			out_ready <= 1'b1;
		end
	end

	// register write: setup cycle then access cycle
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		blur_sb.write_reg(idx, val);
	endtask

	// stop sending, let every expected result drain, then cover the pipeline tail
	task automatic drain();
		valid <= 1'b0;
		while (blur_sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// full register set; drains first so the block is idle
	task automatic set_frame(int unsigned w, int unsigned h, int unsigned wc,
			int unsigned w1, int unsigned w2, int unsigned w4,
			int unsigned w5, int unsigned w8);
		drain();
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_W0, wc);
		write_reg(REG_W1, w1);
		write_reg(REG_W2, w2);
		write_reg(REG_W4, w4);
		write_reg(REG_W5, w5);
		write_reg(REG_W8, w8);
	endtask

	// random weights roughly normalised to 65536 with a positive centre
	task automatic set_random_frame(int unsigned w, int unsigned h);
		int unsigned w1, w2, w4, w5, w8, rest;
		w1 = $urandom_range(0, 4000);
		w2 = $urandom_range(0, 3000);
		w4 = $urandom_range(0, 2000);
		w5 = $urandom_range(0, 1200);
		w8 = $urandom_range(0, 800);
		rest = 4 * (w1 + w2 + w4 + w8) + 8 * w5;
		set_frame(w, h, (rest >= 65535) ? 1 : 65536 - rest, w1, w2, w4, w5, w8);
	endtask

	// one pixel beat, held until taken, then an optional source gap
	task automatic send_pixel(logic [7:0] px, logic fs);
		int gap;
		pixel_value <= px;
		frame_start <= fs;
		valid <= 1'b1;
		do @(posedge clk); while (!ready);
		blur_sb.note_pixel(px, fs);
		gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 16) : 0;
		if (gap > 0) begin
			valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_frame(int unsigned npix, bit noise);
		for (int unsigned i = 0; i < npix; i++)
			send_pixel($urandom_range(0, 255),
				(i == 0) || (noise && $urandom_range(0, 40) == 0));
	endtask

	initial begin
		int unsigned sent, w, h, n;
		blur_sb = new();
		calm = 1'b0;
		sink_stall = 0;
		sink_run = 0;
		arst_n = 1'b0;
		valid = 1'b0;
		pixel_value = '0;
		frame_start = 1'b0;
		out_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: smallest frame with results, pixels at zero and full scale, saturating weights
		set_frame(5, 5, 65535, 65535, 65535, 65535, 65535, 65535);
		for (int i = 0; i < 25; i++)
			send_pixel((i % 3 == 0) ? 8'd0 : 8'd255, i == 0);
		// all-zero weights, then a frame restarted part way through
		set_frame(5, 5, 0, 0, 0, 0, 0, 0);
		for (int i = 0; i < 25; i++)
			send_pixel(8'd255, i == 0 || i == 12);

		// widths and heights above the maximum saturate; too short for results
		set_frame(2047, 8191, 65535, 0, 0, 0, 0, 0);
		send_frame(40, 0);
		// zero width and height act like one: nothing emitted
		set_frame(0, 0, 65535, 0, 0, 0, 0, 0);
		send_frame(20, 0);

		// random frames, mostly well formed, occasionally restarted mid-frame
		sent = 0;
		while (sent < 520) begin
			if (sent > 440) calm = 1'b1;
			w = $urandom_range(5, 12);
			h = $urandom_range(5, 8);
			set_random_frame(w, h);
			n = w * h + $urandom_range(0, w);
			send_frame(n, $urandom_range(0, 3) == 0);
			sent += n;
		end
		valid <= 1'b0;

		drain();
		if (blur_sb.failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
